>>> sv/bss_pkg.sv
// Shared types, codes and constants of the battery system supervisor.
// Used by the register block, the step logic and the top level.
package bss_pkg;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned StaleW = 16;
  localparam int unsigned WaitW  = 20;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Supervisor states
  typedef enum logic [2:0] {
    ST_UNINIT    = 3'd0,
    ST_INIT      = 3'd1,
    ST_CALIB     = 3'd2,
    ST_INACTIVE  = 3'd3,
    ST_OPERATING = 3'd4,
    ST_FAULT     = 3'd5
  } bss_state_e;

  // Contactor commands
  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_CALIBRATE  = 3'd1,
    CMD_OPEN       = 3'd2,
    CMD_CLOSE      = 3'd3,
    CMD_FORCE_OPEN = 3'd4
  } bss_cmd_e;

  // Pending system requests
  typedef enum logic [1:0] {
    REQ_NONE      = 2'd0,
    REQ_RUN       = 2'd1,
    REQ_CALIBRATE = 2'd2,
    REQ_STOP      = 2'd3
  } bss_req_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BATTERY_STALE = 3'd0,
    REG_OUTPUT_STALE  = 3'd1,
    REG_CONTACT_STALE = 3'd2,
    REG_CURRENT_STALE = 3'd3,
    REG_CELL_STALE    = 3'd4,
    REG_TEMP_STALE    = 3'd5,
    REG_INIT_WAIT     = 3'd6,
    REG_CALIB_TIMEOUT = 3'd7
  } bss_reg_e;

  // Reset values and fixed delays
  localparam logic [StaleW-1:0] FastStaleRst    = 16'd1000;
  localparam logic [StaleW-1:0] SlowStaleRst    = 16'd5000;
  localparam logic [WaitW-1:0]  InitWaitRst     = 20'd10000;
  localparam logic [WaitW-1:0]  CalibTimeoutRst = 20'd120000;
  localparam logic [TimeW-1:0]  RunDelayMs      = 32'd2000;

  typedef struct packed {
    logic [StaleW-1:0] battery_stale_ms;
    logic [StaleW-1:0] output_stale_ms;
    logic [StaleW-1:0] contactor_stale_ms;
    logic [StaleW-1:0] current_stale_ms;
    logic [StaleW-1:0] cell_stale_ms;
    logic [StaleW-1:0] temperature_stale_ms;
    logic [WaitW-1:0]  init_wait_ms;
    logic [WaitW-1:0]  calib_timeout_ms;
  } bss_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] battery_stamp;
    logic [TimeW-1:0] output_stamp;
    logic [TimeW-1:0] neg_contactor_stamp;
    logic [TimeW-1:0] pos_contactor_stamp;
    logic [TimeW-1:0] current_stamp;
    logic [TimeW-1:0] cell_stamp;
    logic [TimeW-1:0] temperature_stamp;
    logic             fatal_event;
    logic             calibration_idle;
    bss_req_e         system_request;
    logic             already_calibrated;
  } bss_item_t;

  typedef struct packed {
    bss_state_e system_state;
    bss_cmd_e   contactor_command;
    logic       calibration_start;
    logic       request_clear;
    logic       calibration_timed_out;
  } bss_result_t;

  // Reading is fresh when the wrapped age is within the limit
  function automatic logic is_fresh(input logic [TimeW-1:0] now,
                                    input logic [TimeW-1:0] stamp,
                                    input logic [StaleW-1:0] limit);
    logic [TimeW-1:0] age;
    age = now - stamp;
    return age <= {{(TimeW-StaleW){1'b0}}, limit};
  endfunction

  // Wrapped time since entry has reached the limit
  function automatic logic elapsed(input logic [TimeW-1:0] now,
                                   input logic [TimeW-1:0] since,
                                   input logic [TimeW-1:0] limit);
    logic [TimeW-1:0] dt;
    dt = now - since;
    return dt >= limit;
  endfunction

endpackage

>>> sv/bss_if.sv
// Valid/ready channel interfaces for supervisor ticks and results.
// Depends on nothing; widths follow the supervisor field list.
interface bss_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [31:0] battery_stamp;
  logic [31:0] output_stamp;
  logic [31:0] neg_contactor_stamp;
  logic [31:0] pos_contactor_stamp;
  logic [31:0] current_stamp;
  logic [31:0] cell_stamp;
  logic [31:0] temperature_stamp;
  logic        fatal_event;
  logic        calibration_idle;
  logic [1:0]  system_request;
  logic        already_calibrated;

  modport source (
    output valid, now_ms, battery_stamp, output_stamp, neg_contactor_stamp,
           pos_contactor_stamp, current_stamp, cell_stamp, temperature_stamp,
           fatal_event, calibration_idle, system_request, already_calibrated,
    input  ready
  );
  modport sink (
    input  valid, now_ms, battery_stamp, output_stamp, neg_contactor_stamp,
           pos_contactor_stamp, current_stamp, cell_stamp, temperature_stamp,
           fatal_event, calibration_idle, system_request, already_calibrated,
    output ready
  );
endinterface

interface bss_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] system_state;
  logic [2:0] contactor_command;
  logic       calibration_start;
  logic       request_clear;
  logic       calibration_timed_out;

  modport source (
    output valid, system_state, contactor_command, calibration_start,
           request_clear, calibration_timed_out,
    input  ready
  );
  modport sink (
    input  valid, system_state, contactor_command, calibration_start,
           request_clear, calibration_timed_out,
    output ready
  );
endinterface

>>> sv/battery_system_supervisor_fsm.sv
// Battery system supervisor, top level: one tick request in, one result out.
// Depends on bss_pkg, bss_if (channels), bss_regs and bss_step.
//
// Each tick request is taken into an input register, evaluated by the step
// logic and written with the supervisor state into the result register. A
// new request can be accepted every cycle while the sink takes results: the
// state and entry-time registers close a loop through the step logic, and the
// input register can still take one request while a finished result waits
// for the sink. Configuration goes through the APB port with zero wait
// states and should be written only while no tick is in flight.
module battery_system_supervisor_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bss_in_if.sink                    in_i,
  bss_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bss_pkg::AddrW-1:0] paddr,
  input  logic [bss_pkg::DataW-1:0] pwdata,
  output logic [bss_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  bss_pkg::bss_cfg_t    cfg;
  bss_pkg::bss_item_t   in_item;
  bss_pkg::bss_item_t   item_q;
  logic                 item_vld_q;
  bss_pkg::bss_state_e  state_q;
  bss_pkg::bss_state_e  state_d;
  logic [31:0]          entry_q;
  logic [31:0]          entry_d;
  bss_pkg::bss_result_t res_d;
  bss_pkg::bss_result_t res_q;
  logic                 res_vld_q;
  logic                 advance;
  logic                 in_fire;

  bss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Gather the request payload
  assign in_item.now_ms              = in_i.now_ms;
  assign in_item.battery_stamp       = in_i.battery_stamp;
  assign in_item.output_stamp        = in_i.output_stamp;
  assign in_item.neg_contactor_stamp = in_i.neg_contactor_stamp;
  assign in_item.pos_contactor_stamp = in_i.pos_contactor_stamp;
  assign in_item.current_stamp       = in_i.current_stamp;
  assign in_item.cell_stamp          = in_i.cell_stamp;
  assign in_item.temperature_stamp   = in_i.temperature_stamp;
  assign in_item.fatal_event         = in_i.fatal_event;
  assign in_item.calibration_idle    = in_i.calibration_idle;
  assign in_item.system_request      = bss_pkg::bss_req_e'(in_i.system_request);
  assign in_item.already_calibrated  = in_i.already_calibrated;

  // Advance when the result register is free or being drained
  assign advance    = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item;
    end
  end

  bss_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .entry_i  (entry_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .entry_o  (entry_d),
    .result_o (res_d)
  );

  // State and entry time update as each request retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bss_pkg::ST_UNINIT;
      entry_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
      entry_q <= entry_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid                 = res_vld_q;
  assign out_o.system_state          = res_q.system_state;
  assign out_o.contactor_command     = res_q.contactor_command;
  assign out_o.calibration_start     = res_q.calibration_start;
  assign out_o.request_clear         = res_q.request_clear;
  assign out_o.calibration_timed_out = res_q.calibration_timed_out;

  // Fault is sticky until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bss_pkg::ST_FAULT |=> state_q == bss_pkg::ST_FAULT)
    else $error("supervisor left fault state");

  // State only moves when a request retires
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q) && $stable(entry_q))
    else $error("state changed without a retiring request");

  // Fault result forces open unless it came from a calibration timeout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.system_state == bss_pkg::ST_FAULT &&
    !res_q.calibration_timed_out |->
      res_q.contactor_command == bss_pkg::CMD_FORCE_OPEN)
    else $error("fault result without force open");

  // Calibration start always pairs with the calibrate command and state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.calibration_start |->
      res_q.contactor_command == bss_pkg::CMD_CALIBRATE &&
      res_q.system_state == bss_pkg::ST_CALIB)
    else $error("calibration start without calibrate command");

endmodule

>>> sv/bss_regs.sv
// APB configuration registers of the supervisor: stale limits and timeouts.
// Depends on bss_pkg for the register indexes, reset values and config struct.
module bss_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bss_pkg::AddrW-1:0] paddr,
  input  logic [bss_pkg::DataW-1:0] pwdata,
  output logic [bss_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output bss_pkg::bss_cfg_t         cfg_o
);

  bss_pkg::bss_cfg_t cfg_q;
  bss_pkg::bss_reg_e idx;
  logic              wr_en;

  assign idx    = bss_pkg::bss_reg_e'(paddr[bss_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write the addressed register in the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.battery_stale_ms     <= bss_pkg::FastStaleRst;
      cfg_q.output_stale_ms      <= bss_pkg::FastStaleRst;
      cfg_q.contactor_stale_ms   <= bss_pkg::FastStaleRst;
      cfg_q.current_stale_ms     <= bss_pkg::FastStaleRst;
      cfg_q.cell_stale_ms        <= bss_pkg::SlowStaleRst;
      cfg_q.temperature_stale_ms <= bss_pkg::SlowStaleRst;
      cfg_q.init_wait_ms         <= bss_pkg::InitWaitRst;
      cfg_q.calib_timeout_ms     <= bss_pkg::CalibTimeoutRst;
    end else if (wr_en) begin
      unique case (idx)
        bss_pkg::REG_BATTERY_STALE: cfg_q.battery_stale_ms     <= pwdata[15:0];
        bss_pkg::REG_OUTPUT_STALE:  cfg_q.output_stale_ms      <= pwdata[15:0];
        bss_pkg::REG_CONTACT_STALE: cfg_q.contactor_stale_ms   <= pwdata[15:0];
        bss_pkg::REG_CURRENT_STALE: cfg_q.current_stale_ms     <= pwdata[15:0];
        bss_pkg::REG_CELL_STALE:    cfg_q.cell_stale_ms        <= pwdata[15:0];
        bss_pkg::REG_TEMP_STALE:    cfg_q.temperature_stale_ms <= pwdata[15:0];
        bss_pkg::REG_INIT_WAIT:     cfg_q.init_wait_ms         <= pwdata[19:0];
        bss_pkg::REG_CALIB_TIMEOUT: cfg_q.calib_timeout_ms     <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero extended
  always_comb begin
    unique case (idx)
      bss_pkg::REG_BATTERY_STALE: prdata = {16'b0, cfg_q.battery_stale_ms};
      bss_pkg::REG_OUTPUT_STALE:  prdata = {16'b0, cfg_q.output_stale_ms};
      bss_pkg::REG_CONTACT_STALE: prdata = {16'b0, cfg_q.contactor_stale_ms};
      bss_pkg::REG_CURRENT_STALE: prdata = {16'b0, cfg_q.current_stale_ms};
      bss_pkg::REG_CELL_STALE:    prdata = {16'b0, cfg_q.cell_stale_ms};
      bss_pkg::REG_TEMP_STALE:    prdata = {16'b0, cfg_q.temperature_stale_ms};
      bss_pkg::REG_INIT_WAIT:     prdata = {12'b0, cfg_q.init_wait_ms};
      bss_pkg::REG_CALIB_TIMEOUT: prdata = {12'b0, cfg_q.calib_timeout_ms};
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> sv/bss_step.sv
// Next-state and result logic of the supervisor for one tick.
// Depends on bss_pkg for states, commands, requests and the age checks.
module bss_step (
  input  bss_pkg::bss_cfg_t    cfg_i,
  input  bss_pkg::bss_state_e  state_i,
  input  logic [31:0]          entry_i,
  input  bss_pkg::bss_item_t   item_i,
  output bss_pkg::bss_state_e  state_o,
  output logic [31:0]          entry_o,
  output bss_pkg::bss_result_t result_o
);

  bss_pkg::bss_state_e cur;
  bss_pkg::bss_state_e nxt;
  bss_pkg::bss_cmd_e   cmd;
  logic                go;
  logic                cal_start;
  logic                req_clr;
  logic                cal_to;
  logic                all_fresh;
  logic                init_done;
  logic                calib_expired;
  logic                run_ok;

  // Sensor age checks run in parallel
  assign all_fresh =
    bss_pkg::is_fresh(item_i.now_ms, item_i.battery_stamp, cfg_i.battery_stale_ms) &&
    bss_pkg::is_fresh(item_i.now_ms, item_i.output_stamp, cfg_i.output_stale_ms) &&
    bss_pkg::is_fresh(item_i.now_ms, item_i.neg_contactor_stamp,
                      cfg_i.contactor_stale_ms) &&
    bss_pkg::is_fresh(item_i.now_ms, item_i.pos_contactor_stamp,
                      cfg_i.contactor_stale_ms) &&
    bss_pkg::is_fresh(item_i.now_ms, item_i.current_stamp, cfg_i.current_stale_ms) &&
    bss_pkg::is_fresh(item_i.now_ms, item_i.cell_stamp, cfg_i.cell_stale_ms) &&
    bss_pkg::is_fresh(item_i.now_ms, item_i.temperature_stamp,
                      cfg_i.temperature_stale_ms);

  // Time-in-state checks
  assign init_done     = bss_pkg::elapsed(item_i.now_ms, entry_i,
                                          {12'b0, cfg_i.init_wait_ms});
  assign calib_expired = bss_pkg::elapsed(item_i.now_ms, entry_i,
                                          {12'b0, cfg_i.calib_timeout_ms});
  assign run_ok        = bss_pkg::elapsed(item_i.now_ms, entry_i, bss_pkg::RunDelayMs);

  // Fatal event overrides first, then the per-state transitions
  always_comb begin
    cur = state_i;
    go  = 1'b0;
    if (cur != bss_pkg::ST_FAULT && item_i.fatal_event) begin
      cur = bss_pkg::ST_FAULT;
      go  = 1'b1;
    end
    nxt       = cur;
    cmd       = bss_pkg::CMD_NONE;
    cal_start = 1'b0;
    req_clr   = 1'b0;
    cal_to    = 1'b0;
    unique case (cur)
      bss_pkg::ST_UNINIT: begin
        nxt = bss_pkg::ST_INIT;
        go  = 1'b1;
      end
      bss_pkg::ST_INIT: begin
        if (all_fresh && init_done) begin
          go = 1'b1;
          if (item_i.already_calibrated) begin
            nxt = bss_pkg::ST_INACTIVE;
          end else begin
            cmd       = bss_pkg::CMD_CALIBRATE;
            cal_start = 1'b1;
            nxt       = bss_pkg::ST_CALIB;
          end
        end
      end
      bss_pkg::ST_CALIB: begin
        if (item_i.calibration_idle) begin
          cmd = bss_pkg::CMD_OPEN;
          nxt = bss_pkg::ST_INACTIVE;
          go  = 1'b1;
        end else if (calib_expired) begin
          cal_to = 1'b1;
          nxt    = bss_pkg::ST_FAULT;
          go     = 1'b1;
        end
      end
      bss_pkg::ST_INACTIVE: begin
        if (item_i.system_request == bss_pkg::REQ_RUN && run_ok) begin
          nxt = bss_pkg::ST_OPERATING;
          go  = 1'b1;
        end else if (item_i.system_request == bss_pkg::REQ_CALIBRATE) begin
          req_clr   = 1'b1;
          cmd       = bss_pkg::CMD_CALIBRATE;
          cal_start = 1'b1;
          nxt       = bss_pkg::ST_CALIB;
          go        = 1'b1;
        end
      end
      bss_pkg::ST_OPERATING: begin
        cmd = bss_pkg::CMD_CLOSE;
        if (item_i.system_request == bss_pkg::REQ_STOP) begin
          req_clr = 1'b1;
          cmd     = bss_pkg::CMD_OPEN;
          nxt     = bss_pkg::ST_INACTIVE;
          go      = 1'b1;
        end
      end
      // Fault and unused codes hold and force the contactors open
      default: cmd = bss_pkg::CMD_FORCE_OPEN;
    endcase
  end

  assign state_o                        = nxt;
  assign entry_o                        = go ? item_i.now_ms : entry_i;
  assign result_o.system_state          = nxt;
  assign result_o.contactor_command     = cmd;
  assign result_o.calibration_start     = cal_start;
  assign result_o.request_clear         = req_clr;
  assign result_o.calibration_timed_out = cal_to;

endmodule
